>>> src/bcs_pkg.sv
// Shared widths, register codes and helpers for the bilinear cover scaler.
// Used by every module of the block; depends on nothing.
package bcs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SRC_PIXELS = 65536;
  localparam int ADDR_W     = $clog2(SRC_PIXELS);

  localparam int SW_W      = 13;
  localparam int DW_W      = 14;
  localparam int XY_W      = 13;
  localparam int IDX_W     = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int OUT_W     = 4 * CH_W;
  localparam int POS_W     = 32;
  localparam int IP_W      = POS_W - FRAC_BITS;
  localparam int WGT_W     = FRAC_BITS + 1;

  localparam int PROD_W = SW_W + DW_W;
  localparam int DIV_W  = PROD_W + FRAC_BITS + 1;
  localparam int DVS_W  = DW_W + 1;
  localparam int CUBE_W = 3 * DW_W;
  localparam int RAMP_W = CUBE_W + CH_W;

  // Pipeline stage numbers
  localparam int ST_MEM      = 7;
  localparam int ST_DROP     = 8;
  localparam int ALPHA_Q_ST  = 5 + CH_W;
  localparam int LAST_ST     = ALPHA_Q_ST + 2;

  localparam logic [FRAC_BITS-1:0] FRAC_MASK = '1;
  localparam logic [WGT_W-1:0]     WGT_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CH_W-1:0]      CH_MAX    = '1;
  localparam logic [CH_W-1:0]      OPAQUE    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_TINT_RGB,
    REG_BASE_ALPHA,
    REG_RAMP_ALPHA
  } cfg_reg_t;

  typedef struct packed {
    logic              busy;
    logic [POS_W-1:0]  step;
    logic [POS_W-1:0]  offx;
    logic [POS_W-1:0]  offy;
    logic [CUBE_W-1:0] dcube;
  } geom_t;

  // Exact x / 255 for x up to 255 * 255.
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] t;
    t = {1'b0, x} + {{(CH_W+1){1'b0}}, x[2*CH_W-1:CH_W]} + 1'b1;
    return t[2*CH_W-1:CH_W];
  endfunction

endpackage

>>> src/bcs_div.sv
// Restoring divider, one quotient bit per cycle, for the geometry setup.
// Depends on bcs_pkg for widths.
module bcs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bcs_pkg::DIV_W-1:0]  dividend,
  input  logic [bcs_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [bcs_pkg::DIV_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(bcs_pkg::DIV_W + 1);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [bcs_pkg::DIV_W-1:0]  shreg;
  logic [bcs_pkg::DVS_W-1:0]  rem;
  logic [bcs_pkg::DVS_W-1:0]  dvs;
  logic [bcs_pkg::DVS_W:0]    rsh;
  logic [bcs_pkg::DVS_W-1:0]  rem_next;
  logic                       qbit;

  always_comb begin
    rsh = {rem, shreg[bcs_pkg::DIV_W-1]};
    if (rsh >= {1'b0, dvs}) begin
      qbit     = 1'b1;
      rem_next = bcs_pkg::DVS_W'(rsh - {1'b0, dvs});
    end else begin
      qbit     = 1'b0;
      rem_next = rsh[bcs_pkg::DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
        cnt   <= CNT_W'(bcs_pkg::DIV_W);
        busy  <= 1'b1;
      end else if (busy) begin
        shreg <= {shreg[bcs_pkg::DIV_W-2:0], qbit};
        rem   <= rem_next;
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = shreg;

endmodule

>>> src/bcs_geom.sv
// Geometry setup: cover-fit step and centering offsets in Q16, and D cubed
// for the row ramp. Depends on bcs_pkg and bcs_div.
module bcs_geom (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bcs_pkg::SW_W-1:0]  sw,
  input  logic [bcs_pkg::SW_W-1:0]  sh,
  input  logic [bcs_pkg::DW_W-1:0]  dw,
  input  logic [bcs_pkg::DW_W-1:0]  dh,
  input  logic [bcs_pkg::DW_W-1:0]  dlast,
  output bcs_pkg::geom_t            geo
);

  typedef enum logic [2:0] {G_IDLE, G_MUL, G_SEL, G_PRD, G_STEP, G_OFFX, G_OFFY} gstate_t;

  gstate_t                       state;
  logic [bcs_pkg::PROD_W-1:0]    p1, p2, px, qx, py, qy;
  logic [bcs_pkg::SW_W-1:0]      num;
  logic [bcs_pkg::DW_W-1:0]      den;
  logic [2*bcs_pkg::DW_W-1:0]    dsq;
  logic [bcs_pkg::CUBE_W-1:0]    dcube;
  logic [bcs_pkg::DIV_W-1:0]     dvd;
  logic [bcs_pkg::DVS_W-1:0]     dvs;
  logic                          dstart;
  logic                          ddone;
  logic [bcs_pkg::DIV_W-1:0]     dq;
  logic [bcs_pkg::POS_W-1:0]     step, offx, offy;

  bcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dstart),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (ddone),
    .quotient (dq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= G_IDLE;
      dstart <= 1'b0;
      step   <= '0;
      offx   <= '0;
      offy   <= '0;
      dcube  <= '0;
    end else begin
      dstart <= 1'b0;
      unique case (state)
        G_IDLE: begin
          if (start) state <= G_MUL;
        end
        G_MUL: begin
          p1    <= dw * sh;
          p2    <= dh * sw;
          dsq   <= dlast * dlast;
          state <= G_SEL;
        end
        G_SEL: begin
          if (p1 > p2) begin
            num <= sw;
            den <= dw;
          end else begin
            num <= sh;
            den <= dh;
          end
          dcube <= dsq * dlast;
          state <= G_PRD;
        end
        G_PRD: begin
          px     <= sw * den;
          qx     <= dw * num;
          py     <= sh * den;
          qy     <= dh * num;
          dvd    <= (bcs_pkg::DIV_W'(num) << bcs_pkg::FRAC_BITS) +
                    bcs_pkg::DIV_W'(den >> 1);
          dvs    <= bcs_pkg::DVS_W'(den);
          dstart <= 1'b1;
          state  <= G_STEP;
        end
        G_STEP: begin
          if (ddone) begin
            step   <= dq[bcs_pkg::POS_W-1:0];
            dvd    <= (bcs_pkg::DIV_W'(px - qx) << bcs_pkg::FRAC_BITS) +
                      bcs_pkg::DIV_W'(den);
            dvs    <= {den, 1'b0};
            dstart <= 1'b1;
            state  <= G_OFFX;
          end
        end
        G_OFFX: begin
          if (ddone) begin
            offx   <= dq[bcs_pkg::POS_W-1:0];
            dvd    <= (bcs_pkg::DIV_W'(py - qy) << bcs_pkg::FRAC_BITS) +
                      bcs_pkg::DIV_W'(den);
            dvs    <= {den, 1'b0};
            dstart <= 1'b1;
            state  <= G_OFFY;
          end
        end
        G_OFFY: begin
          if (ddone) begin
            offy  <= dq[bcs_pkg::POS_W-1:0];
            state <= G_IDLE;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign geo.busy  = (state != G_IDLE);
  assign geo.step  = step;
  assign geo.offx  = offx;
  assign geo.offy  = offy;
  assign geo.dcube = dcube;

endmodule

>>> src/bcs_alpha.sv
// Row ramp pipeline: smoothstep numerator, then an 8-stage restoring divide
// by D cubed, one quotient bit per stage. Depends on bcs_pkg.
module bcs_alpha (
  input  logic                               clk,
  input  logic [bcs_pkg::ALPHA_Q_ST:2]       load,
  input  logic [bcs_pkg::XY_W-1:0]           oy,
  input  logic [bcs_pkg::DW_W-1:0]           dlast,
  input  logic [bcs_pkg::CUBE_W-1:0]         dcube,
  input  logic [bcs_pkg::CH_W-1:0]           ramp,
  output logic [bcs_pkg::CH_W-1:0]           quo
);

  localparam int QS = bcs_pkg::ALPHA_Q_ST - bcs_pkg::CH_W;

  logic [bcs_pkg::DW_W:0]            twice, over;
  logic [bcs_pkg::DW_W-1:0]          n_c, n2;
  logic [2*bcs_pkg::DW_W-1:0]        nsq;
  logic [bcs_pkg::DW_W+1:0]          tfac;
  logic [3*bcs_pkg::DW_W+1:0]        mp;
  logic [bcs_pkg::CUBE_W-1:0]        m4;
  logic [bcs_pkg::RAMP_W-1:0]        rp;
  logic [bcs_pkg::RAMP_W-1:0]        rem   [QS:bcs_pkg::ALPHA_Q_ST];
  logic [bcs_pkg::CH_W-1:0]          quo_r [QS:bcs_pkg::ALPHA_Q_ST];

  // n = clamp(2*oy - D, 0, D)
  always_comb begin
    twice = (bcs_pkg::DW_W+1)'(oy) << 1;
    over  = twice - {1'b0, dlast};
    if (twice > {1'b0, dlast}) begin
      if (over > {1'b0, dlast}) n_c = dlast;
      else n_c = over[bcs_pkg::DW_W-1:0];
    end else begin
      n_c = '0;
    end
  end

  assign mp = nsq * tfac;
  assign rp = ramp * m4;

  always_ff @(posedge clk) begin
    if (load[2]) n2 <= n_c;
    if (load[3]) begin
      nsq  <= n2 * n2;
      tfac <= ({2'b0, dlast} << 1) + {2'b0, dlast} - ({2'b0, n2} << 1);
    end
    if (load[4]) m4 <= mp[bcs_pkg::CUBE_W-1:0];
    if (load[QS]) begin
      rem[QS]   <= rp;
      quo_r[QS] <= '0;
    end
  end

  for (genvar i = 0; i < bcs_pkg::CH_W; i++) begin : g_div
    localparam int B = bcs_pkg::CH_W - 1 - i;
    logic [bcs_pkg::RAMP_W-1:0] msh;
    assign msh = bcs_pkg::RAMP_W'(dcube) << B;
    always_ff @(posedge clk) begin
      if (load[QS+1+i]) begin
        if (rem[QS+i] >= msh) begin
          rem[QS+1+i]   <= rem[QS+i] - msh;
          quo_r[QS+1+i] <= quo_r[QS+i] | (bcs_pkg::CH_W'(1) << B);
        end else begin
          rem[QS+1+i]   <= rem[QS+i];
          quo_r[QS+1+i] <= quo_r[QS+i];
        end
      end
    end
  end

  assign quo = quo_r[bcs_pkg::ALPHA_Q_ST];

endmodule

>>> src/bcs_store.sv
// Source pixel store: two copies, each with one write and two read ports,
// so the four bilinear neighbors come out in the same cycle. Depends on bcs_pkg.
module bcs_store (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   we,
  input  logic [3:0][bcs_pkg::ADDR_W-1:0]        addr,
  input  logic [bcs_pkg::PIX_W-1:0]              wdata,
  output logic [3:0][bcs_pkg::PIX_W-1:0]         rdata
);

  logic [bcs_pkg::PIX_W-1:0] mem_a [bcs_pkg::SRC_PIXELS];
  logic [bcs_pkg::PIX_W-1:0] mem_b [bcs_pkg::SRC_PIXELS];

  // Top row neighbors
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem_a[addr[0]] <= wdata;
      rdata[0] <= mem_a[addr[0]];
      rdata[1] <= mem_a[addr[1]];
    end
  end

  // Bottom row neighbors
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem_b[addr[0]] <= wdata;
      rdata[2] <= mem_b[addr[2]];
      rdata[3] <= mem_b[addr[3]];
    end
  end

endmodule

>>> src/bilinear_cover_scaler_dim.sv
// Bilinear cover-fit scaler with per-row dim toward a tint color.
// Depends on bcs_pkg, bcs_geom, bcs_alpha and bcs_store.
//
// Usage: write the seven registers through cfg_we/cfg_index/cfg_data, then
// send items on in_valid/in_ready. An item with kind 0 stores one source
// pixel at src_index; an item with kind 1 asks for the pixel at
// (out_x, out_y) and yields one item on out_valid/out_ready.
// Throughput: one item per cycle while out_ready is high and no geometry
// setup runs. Results come out of a 15-stage pipeline whose longest part
// is the 8-stage divide of the row ramp.
// A write to a size register (0 to 3) starts the geometry setup: three
// serial divides of 44 steps each, while in_ready is low.
// Reset returns sizes to 2x2 source and 1x1 destination, clears tint and
// alphas, zeroes step and offsets, and empties the pipeline; the source
// store is not cleared and must be written before it is sampled.
// When the receiver stalls, the result is held and earlier stages keep
// filling bubbles; in_ready drops once every stage is full.
module bilinear_cover_scaler_dim (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcs_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [bcs_pkg::IDX_W-1:0]         src_index,
  input  logic [bcs_pkg::CH_W-1:0]          src_red,
  input  logic [bcs_pkg::CH_W-1:0]          src_green,
  input  logic [bcs_pkg::CH_W-1:0]          src_blue,
  input  logic [bcs_pkg::XY_W-1:0]          out_x,
  input  logic [bcs_pkg::XY_W-1:0]          out_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bcs_pkg::OUT_W-1:0]         pixel_argb
);

  localparam int LS = bcs_pkg::LAST_ST;
  localparam int QS = bcs_pkg::ALPHA_Q_ST;

  // Configuration
  logic [bcs_pkg::SW_W-1:0]  src_width, src_height, sw_eff, sh_eff;
  logic [bcs_pkg::DW_W-1:0]  dst_width, dst_height, dw_eff, dh_eff, dlast;
  logic [bcs_pkg::PIX_W-1:0] tint_rgb;
  logic [bcs_pkg::CH_W-1:0]  base_alpha, ramp_alpha;
  logic                      dzero;
  logic                      geo_start;
  bcs_pkg::geom_t            geo;

  // Pipeline control
  logic [LS:1] v, load;

  // Stage payload
  logic                          kd   [1:bcs_pkg::ST_MEM];
  logic [bcs_pkg::IDX_W-1:0]     widx [1:6];
  logic [bcs_pkg::PIX_W-1:0]     wrgb [1:6];
  logic [bcs_pkg::XY_W-1:0]      ox1, oy1;
  logic [bcs_pkg::POS_W-1:0]     mx2, my2, sx3, sy3;
  logic [bcs_pkg::IP_W-1:0]      ixr, iyr;
  logic [bcs_pkg::SW_W-1:0]      ix_c, iy_c, ix4, iy4, ix5;
  logic [bcs_pkg::FRAC_BITS-1:0] tx_c, ty_c, tx4, ty4;
  logic [bcs_pkg::WGT_W-1:0]     wa, wb;
  logic [2*bcs_pkg::WGT_W-1:0]   pr00, pr10, pr01, pr11;
  logic [2*bcs_pkg::SW_W-1:0]    rowprod;
  logic [bcs_pkg::ADDR_W-1:0]    rowb5, base;
  logic [3:0][bcs_pkg::WGT_W-1:0]   w5, w6, w7;
  logic [3:0][bcs_pkg::ADDR_W-1:0]  addr6;
  logic [3:0][bcs_pkg::PIX_W-1:0]   px7;
  logic [bcs_pkg::PIX_W-1:0]     c_c;
  logic [bcs_pkg::PIX_W-1:0]     cd [bcs_pkg::ST_DROP:QS];
  logic [bcs_pkg::CH_W-1:0]      quo, qa, a_c, ia_c;
  logic [bcs_pkg::CH_W:0]        asum;
  logic [2:0][2*bcs_pkg::CH_W-1:0] bl_c, bl14;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= bcs_pkg::SW_W'(2);
      src_height <= bcs_pkg::SW_W'(2);
      dst_width  <= bcs_pkg::DW_W'(1);
      dst_height <= bcs_pkg::DW_W'(1);
      tint_rgb   <= '0;
      base_alpha <= '0;
      ramp_alpha <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcs_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data[bcs_pkg::SW_W-1:0];
        bcs_pkg::REG_SRC_HEIGHT: src_height <= cfg_data[bcs_pkg::SW_W-1:0];
        bcs_pkg::REG_DST_WIDTH:  dst_width  <= cfg_data[bcs_pkg::DW_W-1:0];
        bcs_pkg::REG_DST_HEIGHT: dst_height <= cfg_data[bcs_pkg::DW_W-1:0];
        bcs_pkg::REG_TINT_RGB:   tint_rgb   <= cfg_data[bcs_pkg::PIX_W-1:0];
        bcs_pkg::REG_BASE_ALPHA: base_alpha <= cfg_data[bcs_pkg::CH_W-1:0];
        bcs_pkg::REG_RAMP_ALPHA: ramp_alpha <= cfg_data[bcs_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  assign sw_eff = (src_width < bcs_pkg::SW_W'(2)) ? bcs_pkg::SW_W'(2) : src_width;
  assign sh_eff = (src_height < bcs_pkg::SW_W'(2)) ? bcs_pkg::SW_W'(2) : src_height;
  assign dw_eff = (dst_width == '0) ? bcs_pkg::DW_W'(1) : dst_width;
  assign dh_eff = (dst_height == '0) ? bcs_pkg::DW_W'(1) : dst_height;
  assign dlast  = dh_eff - 1'b1;
  assign dzero  = (dlast == '0);

  assign geo_start = cfg_we && (cfg_index == bcs_pkg::REG_SRC_WIDTH ||
                                cfg_index == bcs_pkg::REG_SRC_HEIGHT ||
                                cfg_index == bcs_pkg::REG_DST_WIDTH ||
                                cfg_index == bcs_pkg::REG_DST_HEIGHT);

  bcs_geom u_geom (
    .clk   (clk),
    .rst   (rst),
    .start (geo_start),
    .sw    (sw_eff),
    .sh    (sh_eff),
    .dw    (dw_eff),
    .dh    (dh_eff),
    .dlast (dlast),
    .geo   (geo)
  );

  // ---------------- pipeline control ----------------
  assign load[LS] = !v[LS] || out_ready;
  for (genvar k = 1; k < LS; k++) begin : g_load
    assign load[k] = !v[k] || load[k+1];
  end

  assign in_ready  = load[1] && !geo.busy;
  assign out_valid = v[LS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[1]) v[1] <= in_valid && in_ready;
      for (int k = 2; k <= LS; k++) begin
        // drop store writes once they are past the memory
        if (load[k]) v[k] <= (k == bcs_pkg::ST_DROP) ?
                             (v[k-1] && kd[bcs_pkg::ST_MEM]) : v[k-1];
      end
    end
  end

  // ---------------- stages 1 to 6: address and weights ----------------
  always_ff @(posedge clk) begin
    if (load[1]) begin
      kd[1]   <= kind;
      widx[1] <= src_index;
      wrgb[1] <= {src_red, src_green, src_blue};
      ox1     <= out_x;
      oy1     <= out_y;
    end
    for (int k = 2; k <= 6; k++) begin
      if (load[k]) begin
        kd[k]   <= kd[k-1];
        widx[k] <= widx[k-1];
        wrgb[k] <= wrgb[k-1];
      end
    end
    if (load[bcs_pkg::ST_MEM]) kd[bcs_pkg::ST_MEM] <= kd[bcs_pkg::ST_MEM-1];
  end

  // last column or row: pin to size-2 with a full fraction
  always_comb begin
    ixr = sx3[bcs_pkg::POS_W-1:bcs_pkg::FRAC_BITS];
    iyr = sy3[bcs_pkg::POS_W-1:bcs_pkg::FRAC_BITS];
    if (ixr >= bcs_pkg::IP_W'(sw_eff) - 1'b1) begin
      ix_c = sw_eff - bcs_pkg::SW_W'(2);
      tx_c = bcs_pkg::FRAC_MASK;
    end else begin
      ix_c = ixr[bcs_pkg::SW_W-1:0];
      tx_c = sx3[bcs_pkg::FRAC_BITS-1:0];
    end
    if (iyr >= bcs_pkg::IP_W'(sh_eff) - 1'b1) begin
      iy_c = sh_eff - bcs_pkg::SW_W'(2);
      ty_c = bcs_pkg::FRAC_MASK;
    end else begin
      iy_c = iyr[bcs_pkg::SW_W-1:0];
      ty_c = sy3[bcs_pkg::FRAC_BITS-1:0];
    end
  end

  assign wa      = bcs_pkg::WGT_ONE - {1'b0, tx4};
  assign wb      = bcs_pkg::WGT_ONE - {1'b0, ty4};
  assign pr00    = wa * wb;
  assign pr10    = {1'b0, tx4} * wb;
  assign pr01    = wa * {1'b0, ty4};
  assign pr11    = {1'b0, tx4} * {1'b0, ty4};
  assign rowprod = iy4 * sw_eff;
  assign base    = rowb5 + bcs_pkg::ADDR_W'(ix5);

  always_ff @(posedge clk) begin
    if (load[2]) begin
      mx2 <= ox1 * geo.step;
      my2 <= oy1 * geo.step;
    end
    if (load[3]) begin
      sx3 <= geo.offx + mx2;
      sy3 <= geo.offy + my2;
    end
    if (load[4]) begin
      ix4 <= ix_c;
      tx4 <= tx_c;
      iy4 <= iy_c;
      ty4 <= ty_c;
    end
    if (load[5]) begin
      w5[0] <= pr00[bcs_pkg::FRAC_BITS +: bcs_pkg::WGT_W];
      w5[1] <= pr10[bcs_pkg::FRAC_BITS +: bcs_pkg::WGT_W];
      w5[2] <= pr01[bcs_pkg::FRAC_BITS +: bcs_pkg::WGT_W];
      w5[3] <= pr11[bcs_pkg::FRAC_BITS +: bcs_pkg::WGT_W];
      rowb5 <= rowprod[bcs_pkg::ADDR_W-1:0];
      ix5   <= ix4;
    end
    if (load[6]) begin
      addr6[0] <= kd[5] ? base : bcs_pkg::ADDR_W'(widx[5]);
      addr6[1] <= base + 1'b1;
      addr6[2] <= base + bcs_pkg::ADDR_W'(sw_eff);
      addr6[3] <= base + bcs_pkg::ADDR_W'(sw_eff) + 1'b1;
      w6       <= w5;
    end
    if (load[bcs_pkg::ST_MEM]) w7 <= w6;
  end

  // ---------------- stage 7: source store ----------------
  bcs_store u_store (
    .clk   (clk),
    .en    (load[bcs_pkg::ST_MEM]),
    .we    (v[6] && !kd[6]),
    .addr  (addr6),
    .wdata (wrgb[6]),
    .rdata (px7)
  );

  // ---------------- row alpha, stages 2 to 13 ----------------
  bcs_alpha u_alpha (
    .clk   (clk),
    .load  (load[QS:2]),
    .oy    (oy1),
    .dlast (dlast),
    .dcube (geo.dcube),
    .ramp  (ramp_alpha),
    .quo   (quo)
  );

  // ---------------- stage 8: weighted sums ----------------
  always_comb begin
    logic [bcs_pkg::CH_W+bcs_pkg::WGT_W+1:0] s;
    for (int ch = 0; ch < 3; ch++) begin
      s = px7[0][bcs_pkg::CH_W*ch +: bcs_pkg::CH_W] * w7[0] +
          px7[1][bcs_pkg::CH_W*ch +: bcs_pkg::CH_W] * w7[1] +
          px7[2][bcs_pkg::CH_W*ch +: bcs_pkg::CH_W] * w7[2] +
          px7[3][bcs_pkg::CH_W*ch +: bcs_pkg::CH_W] * w7[3];
      s = s >> bcs_pkg::FRAC_BITS;
      c_c[bcs_pkg::CH_W*ch +: bcs_pkg::CH_W] =
        (s > (bcs_pkg::CH_W+bcs_pkg::WGT_W+2)'(bcs_pkg::CH_MAX)) ?
        bcs_pkg::CH_MAX : s[bcs_pkg::CH_W-1:0];
    end
  end

  // ---------------- stages 14 and 15: blend and pack ----------------
  always_comb begin
    qa   = dzero ? '0 : quo;
    asum = {1'b0, base_alpha} + {1'b0, qa};
    a_c  = asum[bcs_pkg::CH_W] ? bcs_pkg::CH_MAX : asum[bcs_pkg::CH_W-1:0];
    ia_c = bcs_pkg::CH_MAX - a_c;
    for (int ch = 0; ch < 3; ch++) begin
      bl_c[ch] = cd[QS][bcs_pkg::CH_W*ch +: bcs_pkg::CH_W] * ia_c +
                 tint_rgb[bcs_pkg::CH_W*ch +: bcs_pkg::CH_W] * a_c;
    end
  end

  always_ff @(posedge clk) begin
    if (load[bcs_pkg::ST_DROP]) cd[bcs_pkg::ST_DROP] <= c_c;
    for (int k = bcs_pkg::ST_DROP + 1; k <= QS; k++) begin
      if (load[k]) cd[k] <= cd[k-1];
    end
    if (load[QS+1]) bl14 <= bl_c;
    if (load[LS]) begin
      pixel_argb <= {bcs_pkg::OPAQUE, bcs_pkg::div255(bl14[2]),
                     bcs_pkg::div255(bl14[1]), bcs_pkg::div255(bl14[0])};
    end
  end

  // ---------------- checks ----------------
  a_geom_busy: assert property (@(posedge clk) disable iff (rst)
    geo_start |=> geo.busy)
    else $error("geometry setup did not start after a size write");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(geo.busy) |-> $past(geo_start))
    else $error("geometry setup started without a size write");

  a_write_drop: assert property (@(posedge clk) disable iff (rst)
    (v[bcs_pkg::ST_MEM] && !kd[bcs_pkg::ST_MEM] && load[bcs_pkg::ST_DROP])
    |=> !v[bcs_pkg::ST_DROP])
    else $error("store write item passed the memory stage");

endmodule

>>> tb/tb_bilinear_cover_scaler_dim.sv
// Testbench for the bilinear cover scaler with per-row dim.
// Depends on bcs_pkg and bilinear_cover_scaler_dim; predicts each output pixel
// from a mirror of the source store, geometry and dim registers.
module tb_bilinear_cover_scaler_dim;

  localparam logic [bcs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 24;
  localparam int SETUP_CYCLES = 160;
  localparam int HOLD_CYCLES  = 300;

  typedef enum logic {KIND_WRITE = 1'b0, KIND_REQUEST = 1'b1} item_kind_t;

  typedef struct {
    logic [bcs_pkg::XY_W-1:0]  x;
    logic [bcs_pkg::XY_W-1:0]  y;
    logic [bcs_pkg::OUT_W-1:0] argb;
  } pixel_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [bcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bcs_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          kind = 1'b0;
  logic [bcs_pkg::IDX_W-1:0]     src_index = '0;
  logic [bcs_pkg::CH_W-1:0]      src_red = '0;
  logic [bcs_pkg::CH_W-1:0]      src_green = '0;
  logic [bcs_pkg::CH_W-1:0]      src_blue = '0;
  logic [bcs_pkg::XY_W-1:0]      out_x = '0;
  logic [bcs_pkg::XY_W-1:0]      out_y = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [bcs_pkg::OUT_W-1:0]     pixel_argb;

  bilinear_cover_scaler_dim i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .src_index(src_index),
    .src_red(src_red), .src_green(src_green), .src_blue(src_blue),
    .out_x(out_x), .out_y(out_y),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_argb(pixel_argb)
  );

  always #5 clk = ~clk;

  // Mirror of the block state
  logic [bcs_pkg::PIX_W-1:0] src_store [bcs_pkg::SRC_PIXELS];
  bit                        src_written [bcs_pkg::SRC_PIXELS];
  logic [bcs_pkg::SW_W-1:0]  m_src_w = 2, m_src_h = 2;
  logic [bcs_pkg::DW_W-1:0]  m_dst_w = 1, m_dst_h = 1;
  logic [23:0]               m_tint = '0;
  logic [7:0]                m_base = '0, m_ramp = '0;
  logic [bcs_pkg::POS_W-1:0] m_step = '0, m_offx = '0, m_offy = '0;

  pixel_t pending_pixels[$];
  int     err_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_start = 0;
  int     hold_left = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint unsigned eff_src(input longint unsigned v);
    return v < 2 ? 2 : v;
  endfunction

  function automatic longint unsigned eff_dst(input longint unsigned v);
    return v < 1 ? 1 : v;
  endfunction

  function automatic void refit_cover();
    longint unsigned sw, sh, dw, dh, num, den, one;
    sw = eff_src(m_src_w); sh = eff_src(m_src_h);
    dw = eff_dst(m_dst_w); dh = eff_dst(m_dst_h);
    one = longint'(1) << bcs_pkg::FRAC_BITS;
    if (dw * sh > dh * sw) begin
      num = sw; den = dw;
    end else begin
      num = sh; den = dh;
    end
    m_step = bcs_pkg::POS_W'((num * one + den / 2) / den);
    m_offx = bcs_pkg::POS_W'((one * (sw * den - dw * num) + den) / (2 * den));
    m_offy = bcs_pkg::POS_W'((one * (sh * den - dh * num) + den) / (2 * den));
  endfunction

  function automatic void apply_reg(input logic [bcs_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bcs_pkg::CFG_W-1:0] val);
    case (idx)
      bcs_pkg::REG_SRC_WIDTH: begin
        m_src_w = val[bcs_pkg::SW_W-1:0]; refit_cover();
      end
      bcs_pkg::REG_SRC_HEIGHT: begin
        m_src_h = val[bcs_pkg::SW_W-1:0]; refit_cover();
      end
      bcs_pkg::REG_DST_WIDTH: begin
        m_dst_w = val[bcs_pkg::DW_W-1:0]; refit_cover();
      end
      bcs_pkg::REG_DST_HEIGHT: begin
        m_dst_h = val[bcs_pkg::DW_W-1:0]; refit_cover();
      end
      bcs_pkg::REG_TINT_RGB:   m_tint = val[23:0];
      bcs_pkg::REG_BASE_ALPHA: m_base = val[7:0];
      bcs_pkg::REG_RAMP_ALPHA: m_ramp = val[7:0];
      default: ;
    endcase
  endfunction

  // Find the four neighbor addresses and the fractions of one sample point.
  function automatic void locate(input logic [bcs_pkg::XY_W-1:0] x,
                                 input logic [bcs_pkg::XY_W-1:0] y,
                                 output logic [3:0][bcs_pkg::IDX_W-1:0] addr,
                                 output longint unsigned tx, output longint unsigned ty);
    longint unsigned sw, sh, ix, iy, base;
    logic [bcs_pkg::POS_W-1:0] sx, sy;
    sw = eff_src(m_src_w); sh = eff_src(m_src_h);
    sx = m_offx + bcs_pkg::POS_W'(x) * m_step;
    sy = m_offy + bcs_pkg::POS_W'(y) * m_step;
    ix = sx >> bcs_pkg::FRAC_BITS; iy = sy >> bcs_pkg::FRAC_BITS;
    tx = sx[bcs_pkg::FRAC_BITS-1:0]; ty = sy[bcs_pkg::FRAC_BITS-1:0];
    // clamp at the last column and row
    if (ix >= sw - 1) begin
      ix = sw - 2; tx = bcs_pkg::FRAC_MASK;
    end
    if (iy >= sh - 1) begin
      iy = sh - 2; ty = bcs_pkg::FRAC_MASK;
    end
    base = iy * sw + ix;
    addr[0] = bcs_pkg::IDX_W'(base);
    addr[1] = bcs_pkg::IDX_W'(base + 1);
    addr[2] = bcs_pkg::IDX_W'(base + sw);
    addr[3] = bcs_pkg::IDX_W'(base + sw + 1);
  endfunction

  function automatic longint unsigned dim_alpha(input logic [bcs_pkg::XY_W-1:0] y);
    longint unsigned a, d, twice, n;
    a = m_base;
    d = eff_dst(m_dst_h) - 1;
    if (m_ramp != 0 && d != 0) begin
      twice = 2 * longint'(y);
      n = twice > d ? twice - d : 0;
      if (n > d) n = d;
      a += (longint'(m_ramp) * n * n * (3 * d - 2 * n)) / (d * d * d);
    end
    return a > 255 ? 255 : a;
  endfunction

  function automatic logic [bcs_pkg::OUT_W-1:0] scaler_pixel(
    input logic [bcs_pkg::XY_W-1:0] x, input logic [bcs_pkg::XY_W-1:0] y);
    logic [3:0][bcs_pkg::IDX_W-1:0] addr;
    longint unsigned tx, ty, wa, wb, one, a, c, t;
    longint unsigned w[4];
    logic [bcs_pkg::OUT_W-1:0] res;
    one = longint'(1) << bcs_pkg::FRAC_BITS;
    locate(x, y, addr, tx, ty);
    wa = one - tx; wb = one - ty;
    w[0] = (wa * wb) >> bcs_pkg::FRAC_BITS;
    w[1] = (tx * wb) >> bcs_pkg::FRAC_BITS;
    w[2] = (wa * ty) >> bcs_pkg::FRAC_BITS;
    w[3] = (tx * ty) >> bcs_pkg::FRAC_BITS;
    a = dim_alpha(y);
    res = {bcs_pkg::OPAQUE, 24'h0};
    for (int ch = 0; ch < 3; ch++) begin
      c = 0;
      for (int k = 0; k < 4; k++)
        c += longint'(src_store[addr[k]][ch*8 +: 8]) * w[k];
      c = c >> bcs_pkg::FRAC_BITS;
      if (c > 255) c = 255;
      if (a != 0) begin
        t = m_tint[ch*8 +: 8];
        c = (c * (255 - a) + t * a) / 255;
      end
      res[ch*8 +: 8] = c[7:0];
    end
    return res;
  endfunction

  // Offer one item, hold it until taken, then update the mirror.
  task automatic send_item(input item_kind_t k, input logic [bcs_pkg::IDX_W-1:0] idx,
                           input logic [bcs_pkg::PIX_W-1:0] rgb,
                           input logic [bcs_pkg::XY_W-1:0] x,
                           input logic [bcs_pkg::XY_W-1:0] y);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    src_index <= idx;
    {src_red, src_green, src_blue} <= rgb;
    out_x <= x;
    out_y <= y;
    do @(posedge clk); while (!in_ready);
    if (k == KIND_WRITE) begin
      src_store[idx] = rgb;
      src_written[idx] = 1;
    end else begin
      pending_pixels.push_back('{x: x, y: y, argb: scaler_pixel(x, y)});
    end
  endtask

  task automatic write_src(input logic [bcs_pkg::IDX_W-1:0] idx,
                           input logic [bcs_pkg::PIX_W-1:0] rgb);
    send_item(KIND_WRITE, idx, rgb, bcs_pkg::XY_W'($urandom), bcs_pkg::XY_W'($urandom));
  endtask

  // Fill any unwritten neighbor first, then ask for the pixel.
  task automatic request_pixel(input logic [bcs_pkg::XY_W-1:0] x,
                               input logic [bcs_pkg::XY_W-1:0] y);
    logic [3:0][bcs_pkg::IDX_W-1:0] addr;
    longint unsigned tx, ty;
    locate(x, y, addr, tx, ty);
    for (int k = 0; k < 4; k++)
      if (!src_written[addr[k]]) write_src(addr[k], bcs_pkg::PIX_W'($urandom));
    send_item(KIND_REQUEST, bcs_pkg::IDX_W'($urandom), bcs_pkg::PIX_W'($urandom), x, y);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [bcs_pkg::CFG_IDX_W-1:0] idx,
                         input logic [bcs_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
    // let the geometry setup finish
    if (idx <= bcs_pkg::REG_DST_HEIGHT) repeat (SETUP_CYCLES) @(posedge clk);
  endtask

  task automatic set_all(input int sw, input int sh, input int dw, input int dh,
                         input logic [23:0] tint, input int base, input int ramp);
    drain();
    set_reg(bcs_pkg::REG_SRC_WIDTH, bcs_pkg::CFG_W'(sw));
    set_reg(bcs_pkg::REG_SRC_HEIGHT, bcs_pkg::CFG_W'(sh));
    set_reg(bcs_pkg::REG_DST_WIDTH, bcs_pkg::CFG_W'(dw));
    set_reg(bcs_pkg::REG_DST_HEIGHT, bcs_pkg::CFG_W'(dh));
    set_reg(bcs_pkg::REG_TINT_RGB, tint);
    set_reg(bcs_pkg::REG_BASE_ALPHA, bcs_pkg::CFG_W'(base));
    set_reg(bcs_pkg::REG_RAMP_ALPHA, bcs_pkg::CFG_W'(ramp));
  endtask

  function automatic int pick_size(input int lo, input int hi);
    int r;
    r = $urandom_range(19);
    if (r == 0) return hi;
    if (r == 1) return lo;
    if (r < 5) return $urandom_range(lo, 300);
    return $urandom_range(lo, 40);
  endfunction

  task automatic test_reset_state();
    // geometry is all zero until a size write: every request samples (0,0)
    for (int i = 0; i < 4; i++) write_src(bcs_pkg::IDX_W'(i), bcs_pkg::PIX_W'($urandom));
    request_pixel(0, 0);
    request_pixel('1, '1);
    drain();
  endtask

  task automatic test_directed();
    write_src('1, '1);
    write_src('0, '0);
    set_all(3, 2, 5, 5, 24'h102030, 40, 255);
    request_pixel(0, 0);
    request_pixel(4, 4);
    request_pixel(2, 2);
    request_pixel('1, '1);
    request_pixel('1, 0);
    // saturated dim and a tint at full white
    set_all(5, 7, 9, 4, 24'hFFFFFF, 255, 255);
    request_pixel(8, 3);
    request_pixel(0, 1);
    // undersized registers fall back to 2 and 1, ramp off with one row
    set_all(0, 1, 0, 0, 24'h00FF00, 128, 200);
    request_pixel(0, 0);
    request_pixel(1, 3);
    // a write to an unused index leaves everything alone
    drain();
    set_reg(REG_UNUSED, '1);
    request_pixel(0, 0);
    // a 4096 by 4096 source wraps store addresses
    set_all(4096, 4096, 8192, 1, 24'hABCDEF, 0, 77);
    request_pixel(8191, 0);
    request_pixel(4000, 5);
    drain();
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall);
    int dw, dh;
    dw = pick_size(1, 8192);
    dh = pick_size(1, 8192);
    set_all(pick_size(2, 4096), pick_size(2, 4096), dw, dh, 24'($urandom),
            ($urandom_range(3) == 0) ? 255 : $urandom_range(255),
            ($urandom_range(3) == 0) ? 0 : $urandom_range(255));
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        write_src(bcs_pkg::IDX_W'($urandom), bcs_pkg::PIX_W'($urandom));
      else if ($urandom_range(9) < 2)
        request_pixel(bcs_pkg::XY_W'($urandom), bcs_pkg::XY_W'($urandom));
      else
        request_pixel(bcs_pkg::XY_W'($urandom_range(dw - 1)),
                      bcs_pkg::XY_W'($urandom_range(dh - 1)));
    end
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_all(6, 6, 6, 6, 24'h404040, 10, 90);
    hold_start = 1;
    for (int i = 0; i < 60; i++)
      request_pixel(bcs_pkg::XY_W'($urandom_range(5)), bcs_pkg::XY_W'($urandom_range(5)));
    drain();
  endtask

  // Receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 0;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t exp_pix;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h", pixel_argb));
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (pixel_argb !== exp_pix.argb)
          report_mismatch($sformatf("pixel (%0d,%0d): got %h want %h",
                                    exp_pix.x, exp_pix.y, pixel_argb, exp_pix.argb));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random_phase(30, 0, 0);
    test_random_phase(30, 55, 0);
    test_random_phase(30, 0, 55);
    test_random_phase(30, 33, 33);
    test_backpressure();
    drain();
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixels never came", pending_pixels.size()));
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
